// File: hdl/ic_pkg.sv
`default_nettype none
package ic_pkg;

	localparam int DATA_W          = 32;
	localparam int IDX_W           = 5;
	localparam int NUM_SOURCES_DEF = 32;

	// request types
	localparam logic [1:0] REQ_TICK  = 2'd0;
	localparam logic [1:0] REQ_WRITE = 2'd1;
	localparam logic [1:0] REQ_READ  = 2'd2;

	// register selects
	localparam logic [3:0] REG_CFG0   = 4'd0;
	localparam logic [3:0] REG_CFG1   = 4'd1;
	localparam logic [3:0] REG_CFG2   = 4'd2;
	localparam logic [3:0] REG_ASSIGN = 4'd3;
	localparam logic [3:0] REG_SOURCE = 4'd4;
	localparam logic [3:0] REG_MASK   = 4'd5;
	localparam logic [3:0] REG_WAKE   = 4'd6;
	localparam logic [3:0] REG_RISE   = 4'd7;
	localparam logic [3:0] REG_FALL   = 4'd8;
	localparam logic [3:0] REG_REQ0   = 4'd9;
	localparam logic [3:0] REG_REQ1   = 4'd10;

	// source kind codes {cfg2, cfg1, cfg0}
	localparam logic [2:0] KIND_RISE = 3'b001;
	localparam logic [2:0] KIND_FALL = 3'b010;
	localparam logic [2:0] KIND_HIGH = 3'b101;
	localparam logic [2:0] KIND_LOW  = 3'b110;

	typedef struct packed {
		logic [1:0]        req_type;
		logic [3:0]        reg_select;
		logic              write_clear;
		logic [DATA_W-1:0] write_bits;
		logic [DATA_W-1:0] source_levels;
	} in_item_t;

	typedef struct packed {
		logic [DATA_W-1:0] read_data;
		logic              req0_line;
		logic              req1_line;
		logic              wake_line;
		logic [IDX_W-1:0]  first_req0_index;
	} out_item_t;

	// per-lane update command
	typedef struct packed {
		logic       tick;
		logic       write;
		logic       clear;
		logic [3:0] sel;
		logic       wbit;
		logic       level;
	} lane_cmd_t;

	// per-lane status toward the merge stage
	typedef struct packed {
		logic req0;
		logic req1;
		logic wake;
		logic rd_bit;
	} lane_stat_t;

endpackage
`default_nettype wire

// File: hdl/ic_lane.sv
`default_nettype none
module ic_lane
	import ic_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire lane_cmd_t  cmd,
	input  wire logic [3:0] rd_sel,
	output lane_stat_t      stat
);

	logic [2:0] cfg_q;
	logic       assign_q;
	logic       src_q;
	logic       mask_q;
	logic       wake_q;
	logic       rise_q;
	logic       fall_q;
	logic       prev_q;
	logic       set_val;
	logic       active;
	logic       req0;
	logic       req1;

	// new value of a set/clear bit when this lane's write bit is high
	assign set_val = ~cmd.clear;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q    <= '0;
			assign_q <= 1'b0;
			src_q    <= 1'b0;
			mask_q   <= 1'b0;
			wake_q   <= 1'b0;
			rise_q   <= 1'b0;
			fall_q   <= 1'b0;
			prev_q   <= 1'b0;
		end else if (cmd.tick) begin
			rise_q <= rise_q | (cmd.level & ~prev_q);
			fall_q <= fall_q | (~cmd.level & prev_q);
			prev_q <= cmd.level;
		end else if (cmd.write && cmd.wbit) begin
			case (cmd.sel)
				REG_CFG0:   cfg_q[0] <= set_val;
				REG_CFG1:   cfg_q[1] <= set_val;
				REG_CFG2:   cfg_q[2] <= set_val;
				REG_ASSIGN: assign_q <= set_val;
				REG_SOURCE: src_q    <= set_val;
				REG_MASK:   mask_q   <= set_val;
				REG_WAKE:   wake_q   <= set_val;
				// latches only clear by write
				REG_RISE:   rise_q   <= 1'b0;
				REG_FALL:   fall_q   <= 1'b0;
				default:    ;
			endcase
		end
	end

	always_comb begin
		case (cfg_q)
			KIND_RISE: active = rise_q;
			KIND_FALL: active = fall_q;
			KIND_HIGH: active = prev_q;
			KIND_LOW:  active = ~prev_q;
			default:   active = 1'b0;
		endcase
	end

	assign req0 = active & mask_q & assign_q;
	assign req1 = active & mask_q & ~assign_q;

	always_comb begin
		stat.req0 = req0;
		stat.req1 = req1;
		stat.wake = active & wake_q;
		case (rd_sel)
			REG_CFG0:   stat.rd_bit = cfg_q[0];
			REG_CFG1:   stat.rd_bit = cfg_q[1];
			REG_CFG2:   stat.rd_bit = cfg_q[2];
			REG_ASSIGN: stat.rd_bit = assign_q;
			REG_SOURCE: stat.rd_bit = src_q;
			REG_MASK:   stat.rd_bit = mask_q;
			REG_WAKE:   stat.rd_bit = wake_q;
			REG_RISE:   stat.rd_bit = rise_q;
			REG_FALL:   stat.rd_bit = fall_q;
			REG_REQ0:   stat.rd_bit = req0;
			REG_REQ1:   stat.rd_bit = req1;
			default:    stat.rd_bit = 1'b0;
		endcase
	end

endmodule
`default_nettype wire

// File: hdl/ic_merge.sv
`default_nettype none
module ic_merge
	import ic_pkg::*;
#(
	parameter int NUM_LANES = NUM_SOURCES_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire lane_stat_t stat [NUM_LANES],
	input  wire logic       valid_s1,
	input  wire logic       is_read_s1,
	input  wire logic       rsp_ready,
	output logic            advance,
	output logic            rsp_valid,
	output out_item_t       rsp
);

	logic              rsp_valid_q;
	out_item_t         rsp_q;
	logic [DATA_W-1:0] rd_vec;
	logic              any0;
	logic              any1;
	logic              anyw;
	logic [IDX_W-1:0]  idx;

	// output register frees up when empty or being taken
	assign advance   = ~rsp_valid_q | rsp_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		rd_vec = '0;
		any0   = 1'b0;
		any1   = 1'b0;
		anyw   = 1'b0;
		idx    = '0;
		// descending scan so the lowest pending lane wins
		for (int i = NUM_LANES - 1; i >= 0; i--) begin
			rd_vec[i] = stat[i].rd_bit & is_read_s1;
			any0      = any0 | stat[i].req0;
			any1      = any1 | stat[i].req1;
			anyw      = anyw | stat[i].wake;
			if (stat[i].req0) begin
				idx = IDX_W'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			rsp_q.read_data        <= rd_vec;
			rsp_q.req0_line        <= any0;
			rsp_q.req1_line        <= any1;
			rsp_q.wake_line        <= anyw;
			rsp_q.first_req0_index <= idx;
		end
	end

endmodule
`default_nettype wire

// File: hdl/interrupt_controller_with_edge_detect.sv
`default_nettype none
// Interrupt controller for up to 32 sources with two request lines, edge latches and a
// wake line. Every request item (sample tick, register write, register read or other)
// yields one response item carrying read data, both request lines, the wake line and the
// lowest pending request-0 index, all taken from the state after that item. One item is
// taken per clock while req_ready is high. The lane registers and the stage-one register
// load at the edge that takes a request. The merge stage's output register loads from
// them once it frees up, and the response is offered from that register. A response that
// waits in the output register holds off a new request only while stage one is also full.
// Sources above NUM_SOURCES (or above 32) do not exist and read as zero.
module interrupt_controller_with_edge_detect
	import ic_pkg::*;
#(
	parameter int NUM_SOURCES = NUM_SOURCES_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	output logic           req_ready,
	input  wire in_item_t  req,
	output logic           rsp_valid,
	input  wire logic      rsp_ready,
	output out_item_t      rsp
);

	localparam int NS = (NUM_SOURCES < DATA_W) ? NUM_SOURCES : DATA_W;

	logic       accept;
	logic       advance;
	logic       valid_s1;
	logic       is_read_s1;
	logic [3:0] sel_s1;
	lane_stat_t stat [NS];

	assign req_ready = ~valid_s1 | advance;
	assign accept    = req_valid & req_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			is_read_s1 <= 1'b0;
			sel_s1     <= '0;
		end else if (accept) begin
			valid_s1   <= 1'b1;
			is_read_s1 <= (req.req_type == REQ_READ);
			sel_s1     <= req.reg_select;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	for (genvar g = 0; g < NS; g++) begin : g_lane
		lane_cmd_t cmd;

		always_comb begin
			cmd.tick  = accept && (req.req_type == REQ_TICK);
			cmd.write = accept && (req.req_type == REQ_WRITE);
			cmd.clear = req.write_clear;
			cmd.sel   = req.reg_select;
			cmd.wbit  = req.write_bits[g];
			cmd.level = req.source_levels[g];
		end

		ic_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (cmd),
			.rd_sel (sel_s1),
			.stat   (stat[g])
		);
	end

	ic_merge #(
		.NUM_LANES (NS)
	) u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.stat       (stat),
		.valid_s1   (valid_s1),
		.is_read_s1 (is_read_s1),
		.rsp_ready  (rsp_ready),
		.advance    (advance),
		.rsp_valid  (rsp_valid),
		.rsp        (rsp)
	);

endmodule
`default_nettype wire

// File: sim/irq_response_checker.sv
`default_nettype none
module irq_response_checker
	import ic_pkg::*;
#(
	parameter int NUM_SOURCES = NUM_SOURCES_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	input  wire logic      req_ready,
	input  wire in_item_t  req,
	input  wire logic      rsp_valid,
	input  wire logic      rsp_ready,
	input  wire out_item_t rsp,
	output int             fail_count,
	output int             pending
);

	localparam logic [DATA_W-1:0] SRC_MASK = (NUM_SOURCES >= DATA_W) ? '1 :
		DATA_W'((64'd1 << NUM_SOURCES) - 64'd1);

	logic [DATA_W-1:0] cfg0_q, cfg1_q, cfg2_q, assign_q, source_q;
	logic [DATA_W-1:0] mask_q, wake_q, rise_q, fall_q, levels_q;

	out_item_t expected_responses[$];
	out_item_t want;

	initial begin
		fail_count = 0;
		pending    = 0;
	end

	function automatic logic [DATA_W-1:0] active_lines();
		logic [DATA_W-1:0] act;
		logic [2:0]        kind;
		act = '0;
		for (int i = 0; i < DATA_W; i++) begin
			kind = {cfg2_q[i], cfg1_q[i], cfg0_q[i]};
			case (kind)
				KIND_RISE: act[i] = rise_q[i];
				KIND_FALL: act[i] = fall_q[i];
				KIND_HIGH: act[i] = levels_q[i];
				KIND_LOW:  act[i] = ~levels_q[i];
				default:   act[i] = 1'b0;
			endcase
		end
		return act & SRC_MASK;
	endfunction

	function automatic logic [DATA_W-1:0] set_or_clear(logic [DATA_W-1:0] cur, logic clr,
			logic [DATA_W-1:0] bits);
		return clr ? (cur & ~bits) : (cur | bits);
	endfunction

	// applies one request item to the shadow registers and returns its response
	function automatic out_item_t service_request(in_item_t it);
		logic [DATA_W-1:0] bits, lv, act, r0, r1;
		out_item_t         res;
		bits = it.write_bits & SRC_MASK;
		lv   = it.source_levels & SRC_MASK;
		case (it.req_type)
			REQ_TICK: begin
				rise_q   = rise_q | (lv & ~levels_q);
				fall_q   = fall_q | (~lv & levels_q & SRC_MASK);
				levels_q = lv;
			end
			REQ_WRITE: begin
				case (it.reg_select)
					REG_CFG0:   cfg0_q   = set_or_clear(cfg0_q, it.write_clear, bits);
					REG_CFG1:   cfg1_q   = set_or_clear(cfg1_q, it.write_clear, bits);
					REG_CFG2:   cfg2_q   = set_or_clear(cfg2_q, it.write_clear, bits);
					REG_ASSIGN: assign_q = set_or_clear(assign_q, it.write_clear, bits);
					REG_SOURCE: source_q = set_or_clear(source_q, it.write_clear, bits);
					REG_MASK:   mask_q   = set_or_clear(mask_q, it.write_clear, bits);
					REG_WAKE:   wake_q   = set_or_clear(wake_q, it.write_clear, bits);
					// latches only clear by write, whatever write_clear says
					REG_RISE:   rise_q   = rise_q & ~bits;
					REG_FALL:   fall_q   = fall_q & ~bits;
					default:    ;
				endcase
			end
			default: ;
		endcase

		act = active_lines();
		r0  = act & mask_q & assign_q;
		r1  = act & mask_q & ~assign_q;

		res = '0;
		if (it.req_type == REQ_READ) begin
			case (it.reg_select)
				REG_CFG0:   res.read_data = cfg0_q;
				REG_CFG1:   res.read_data = cfg1_q;
				REG_CFG2:   res.read_data = cfg2_q;
				REG_ASSIGN: res.read_data = assign_q;
				REG_SOURCE: res.read_data = source_q;
				REG_MASK:   res.read_data = mask_q;
				REG_WAKE:   res.read_data = wake_q;
				REG_RISE:   res.read_data = rise_q;
				REG_FALL:   res.read_data = fall_q;
				REG_REQ0:   res.read_data = r0;
				REG_REQ1:   res.read_data = r1;
				default:    res.read_data = '0;
			endcase
		end
		res.req0_line = |r0;
		res.req1_line = |r1;
		res.wake_line = |(act & wake_q);
		for (int i = DATA_W - 1; i >= 0; i--) begin
			if (r0[i])
				res.first_req0_index = IDX_W'(i);
		end
		return res;
	endfunction

	task automatic check_field(input string field, input logic [DATA_W-1:0] exp_val,
			input logic [DATA_W-1:0] got_val);
		if (exp_val !== got_val) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, field,
				exp_val, got_val);
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			cfg0_q   = '0;
			cfg1_q   = '0;
			cfg2_q   = '0;
			assign_q = '0;
			source_q = '0;
			mask_q   = '0;
			wake_q   = '0;
			rise_q   = '0;
			fall_q   = '0;
			levels_q = '0;
			expected_responses.delete();
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (expected_responses.size() == 0) begin
					fail_count++;
					$display("%0t: response with nothing outstanding, expected none, actual %h",
						$time, rsp);
				end else begin
					want = expected_responses.pop_front();
					check_field("read_data", want.read_data, rsp.read_data);
					check_field("req0_line", DATA_W'(want.req0_line), DATA_W'(rsp.req0_line));
					check_field("req1_line", DATA_W'(want.req1_line), DATA_W'(rsp.req1_line));
					check_field("wake_line", DATA_W'(want.wake_line), DATA_W'(rsp.wake_line));
					check_field("first_req0_index", DATA_W'(want.first_req0_index),
						DATA_W'(rsp.first_req0_index));
				end
			end
			if (req_valid && req_ready)
				expected_responses.push_back(service_request(req));
		end
		pending <= expected_responses.size();
	end

endmodule
`default_nettype wire

// File: sim/interrupt_controller_with_edge_detect_tb.sv
`default_nettype none
module interrupt_controller_with_edge_detect_tb;
	import ic_pkg::*;

	localparam logic [1:0] REQ_NONE      = 2'd3;
	localparam logic [3:0] REG_UNUSED_LO = 4'd11;
	localparam logic [3:0] REG_UNUSED_HI = 4'd15;
	localparam int RANDOM_ITEMS = 1320;
	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 8;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_ready;
	in_item_t  req       = '0;
	logic      rsp_valid;
	logic      rsp_ready = 1'b0;
	out_item_t rsp;

	int fail_count;
	int pending;
	int stall_left  = 0;
	int idle_cycles = 0;
	bit calm        = 1'b0;
	logic [DATA_W-1:0] last_levels = '0;

	interrupt_controller_with_edge_detect u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	irq_response_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// mostly no gap, some short, a few long
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		else if (roll < 90)
			return $urandom_range(1, 3);
		else if (roll < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic logic [DATA_W-1:0] pick_bits();
		case ($urandom_range(0, 4))
			0: return $urandom;
			1: return DATA_W'(1) << $urandom_range(0, DATA_W - 1);
			2: return $urandom & $urandom & $urandom;
			3: return '1;
			default: return $urandom | $urandom;
		endcase
	endfunction

	function automatic logic [DATA_W-1:0] pick_levels(logic [DATA_W-1:0] prev);
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return $urandom;
			default: return prev ^ ($urandom & $urandom & $urandom);
		endcase
	endfunction

	function automatic in_item_t make_item(logic [1:0] kind, logic [3:0] sel, logic clr,
			logic [DATA_W-1:0] bits, logic [DATA_W-1:0] lv);
		in_item_t it;
		it.req_type      = kind;
		it.reg_select    = sel;
		it.write_clear   = clr;
		it.write_bits    = bits;
		it.source_levels = lv;
		return it;
	endfunction

	task automatic issue(input in_item_t it);
		int gap;
		req_valid <= 1'b1;
		req       <= it;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		gap = calm ? 0 : pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else if (stall_left > 0) begin
			rsp_ready <= 1'b0;
			stall_left--;
		end else begin
			rsp_ready <= 1'b1;
			if (!calm)
				stall_left = pick_gap();
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// reset values, then edges on every line
		issue(make_item(REQ_READ, REG_CFG0, 1'b0, $urandom, $urandom));
		issue(make_item(REQ_TICK, REG_CFG0, 1'b0, '0, '1));
		issue(make_item(REQ_TICK, REG_CFG1, 1'b1, '1, '0));
		// kind code of line i is i mod 8, so every code shows up
		issue(make_item(REQ_WRITE, REG_CFG0, 1'b0, 32'hAAAA_AAAA, $urandom));
		issue(make_item(REQ_WRITE, REG_CFG1, 1'b0, 32'hCCCC_CCCC, $urandom));
		issue(make_item(REQ_WRITE, REG_CFG2, 1'b0, 32'hF0F0_F0F0, $urandom));
		issue(make_item(REQ_WRITE, REG_WAKE, 1'b0, 32'h8000_0002, $urandom));
		issue(make_item(REQ_WRITE, REG_MASK, 1'b0, '1, $urandom));
		issue(make_item(REQ_WRITE, REG_ASSIGN, 1'b0, 32'h0000_FFFF, $urandom));
		issue(make_item(REQ_WRITE, REG_SOURCE, 1'b0, '1, $urandom));
		issue(make_item(REQ_READ, REG_REQ0, 1'b1, $urandom, $urandom));
		issue(make_item(REQ_READ, REG_REQ1, 1'b0, $urandom, $urandom));
		// latch writes clear even with write_clear low
		issue(make_item(REQ_WRITE, REG_RISE, 1'b0, 32'h0000_00FF, $urandom));
		issue(make_item(REQ_WRITE, REG_FALL, 1'b1, '1, $urandom));
		issue(make_item(REQ_READ, REG_RISE, 1'b0, $urandom, $urandom));
		issue(make_item(REQ_READ, REG_FALL, 1'b0, $urandom, $urandom));
		// request vectors and unused selects ignore writes
		issue(make_item(REQ_WRITE, REG_REQ0, 1'b0, '1, $urandom));
		issue(make_item(REQ_WRITE, REG_REQ1, 1'b0, '1, $urandom));
		issue(make_item(REQ_WRITE, REG_UNUSED_HI, 1'b0, '1, $urandom));
		issue(make_item(REQ_READ, REG_UNUSED_LO, 1'b0, $urandom, $urandom));
		issue(make_item(REQ_READ, REG_UNUSED_HI, 1'b1, $urandom, $urandom));
		issue(make_item(REQ_NONE, REG_CFG0, 1'b0, '1, '1));
		issue(make_item(REQ_TICK, REG_MASK, 1'b0, $urandom, '1));
		issue(make_item(REQ_WRITE, REG_MASK, 1'b1, 32'h0000_FFFF, $urandom));
		issue(make_item(REQ_READ, REG_MASK, 1'b0, $urandom, $urandom));
		issue(make_item(REQ_READ, REG_SOURCE, 1'b0, $urandom, $urandom));
		issue(make_item(REQ_WRITE, REG_SOURCE, 1'b1, '1, $urandom));
		last_levels = '1;

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			int pick;
			logic [3:0] sel;
			logic [DATA_W-1:0] lv;
			if (n % 150 == 0)
				calm = ($urandom_range(0, 3) == 0);
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				lv = pick_levels(last_levels);
				last_levels = lv;
				issue(make_item(REQ_TICK, 4'($urandom), 1'($urandom), $urandom, lv));
			end else if (pick < 75) begin
				if ($urandom_range(0, 9) == 0)
					sel = 4'($urandom_range(REG_REQ0, REG_UNUSED_HI));
				else
					sel = 4'($urandom_range(REG_CFG0, REG_FALL));
				issue(make_item(REQ_WRITE, sel, 1'($urandom), pick_bits(), $urandom));
			end else if (pick < 95) begin
				sel = 4'($urandom_range(REG_CFG0, REG_UNUSED_HI));
				issue(make_item(REQ_READ, sel, 1'($urandom), $urandom, $urandom));
			end else begin
				issue(make_item(REQ_NONE, 4'($urandom), 1'($urandom), $urandom, $urandom));
			end
		end
		req_valid <= 1'b0;

		// pending is registered, so it trails the checker's queue size
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
`default_nettype wire
